@@ hdl/grid_occupancy_neighbor_expand_top_defines.svh @@
// Assertion helpers shared by the occupancy grid modules.
`ifndef GRID_OCCUPANCY_NEIGHBOR_EXPAND_TOP_DEFINES_SVH
`define GRID_OCCUPANCY_NEIGHBOR_EXPAND_TOP_DEFINES_SVH

// Same-cycle implication.
`define GONX_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GONX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/gonx_pkg.sv @@
package gonx_pkg;

  localparam int COORD_W = 10;  // input / result coordinate width
  localparam int NB_W    = 11;  // coordinate plus one step
  localparam int CFG_W   = 9;   // grid size register width
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 3;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXPAND = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_LAST_4 = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LAST_8 = 3'd7;

  // Controller -> datapath commands
  typedef struct packed {
    logic             clr;     // clearing sweep write
    logic             ld;      // latch transaction
    logic             rd;      // map read into stage
    logic             wr;      // set/clear write at center
    logic             center;  // zero offset instead of direction
    logic [DIR_W-1:0] dir;
    logic             ack;     // emit set/clear acknowledge
    logic             qresp;   // emit query answer
    logic             eval;    // fold stage into pending neighbor
    logic             fin;     // emit last expand result
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             diag;
    logic             clr_last;
  } dp_status_t;

  // Offset order: N S E W, then diagonals.
  function automatic logic signed [1:0] step_dx(input logic [DIR_W-1:0] d);
    case (d)
      3'd0, 3'd1: step_dx = 2'sd0;
      3'd2, 3'd4, 3'd5: step_dx = 2'sd1;
      default: step_dx = -2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [DIR_W-1:0] d);
    case (d)
      3'd0, 3'd4, 3'd6: step_dy = 2'sd1;
      3'd2, 3'd3: step_dy = 2'sd0;
      default: step_dy = -2'sd1;
    endcase
  endfunction

endpackage

@@ hdl/gonx_ctrl.sv @@
`include "grid_occupancy_neighbor_expand_top_defines.svh"

module gonx_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  gonx_pkg::dp_status_t   status_i,
  output gonx_pkg::ctrl_cmd_t    cmd_o
);
  import gonx_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_QRESP = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [DIR_W-1:0] dir_q, dir_d;
  logic [DIR_W-1:0] last_dir;

  assign last_dir = status_i.diag ? DIR_LAST_8 : DIR_LAST_4;
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.ld = 1'b1;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (status_i.cmd)
          CMD_SET, CMD_CLEAR: begin
            cmd_o.wr     = 1'b1;
            cmd_o.center = 1'b1;
            cmd_o.ack    = 1'b1;
            state_d      = S_IDLE;
          end
          CMD_QUERY: begin
            cmd_o.rd     = 1'b1;
            cmd_o.center = 1'b1;
            state_d      = S_QRESP;
          end
          default: begin
            cmd_o.rd  = 1'b1;
            cmd_o.dir = '0;
            dir_d     = DIR_W'(1);
            state_d   = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.rd   = 1'b1;
        cmd_o.dir  = dir_q;
        cmd_o.eval = 1'b1;
        dir_d      = dir_q + DIR_W'(1);
        if (dir_q == last_dir) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.eval = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      S_QRESP: begin
        cmd_o.qresp = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      dir_q   <= '0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  `GONX_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy,
                   "accepted transaction did not raise busy")
  `GONX_ASSERT_NXT(a_fin_idle, clk_i, rst_ni, cmd_o.fin, !busy,
                   "controller not idle after final result")
  `GONX_ASSERT_NOW(a_one_port, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.clr, cmd_o.rd, cmd_o.wr}),
                   "more than one map access in a cycle")

endmodule

@@ hdl/gonx_dp.sv @@
`include "grid_occupancy_neighbor_expand_top_defines.svh"

module gonx_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gonx_pkg::ctrl_cmd_t           cmd_i,
  output gonx_pkg::dp_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [gonx_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [gonx_pkg::CMD_W-1:0]    command_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_x_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_y_i,
  input  logic                          diagonal_i,
  output logic                          result_valid_o,
  output logic                          occupied_o,
  output logic                          neighbor_valid_o,
  output logic signed [gonx_pkg::COORD_W-1:0] neighbor_x_o,
  output logic signed [gonx_pkg::COORD_W-1:0] neighbor_y_o,
  output logic                          last_o
);
  import gonx_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);

  // configuration
  logic [CFG_W-1:0] grid_w_q, grid_h_q;
  logic [CFG_W-1:0] used_w, used_h;

  // latched transaction
  logic [CMD_W-1:0]         cmd_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic                     diag_q;

  // address path
  logic signed [1:0]      dx, dy;
  logic signed [NB_W-1:0] nx, ny;
  logic                   inb;
  logic [15:0]            xe, ye;
  logic [AW-1:0]          nb_addr;

  // map memory
  logic          map_mem [DEPTH];
  logic [AW-1:0] clr_cnt_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re, mem_wdata;
  logic          rdata_q;

  // read stage and pending neighbor
  logic                     s_inb_q;
  logic [COORD_W-1:0]       s_x_q, s_y_q;
  logic                     pend_v_q;
  logic [COORD_W-1:0]       pend_x_q, pend_y_q;
  logic                     free;

  // result register
  logic               out_v_q, out_v_d;
  logic               occ_q, occ_d, nv_q, nv_d, last_q, last_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;

  // size in use saturates at the map dimensions
  assign used_w = (32'(grid_w_q) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : grid_w_q;
  assign used_h = (32'(grid_h_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : grid_h_q;

  assign dx = cmd_i.center ? 2'sd0 : step_dx(cmd_i.dir);
  assign dy = cmd_i.center ? 2'sd0 : step_dy(cmd_i.dir);
  assign nx = NB_W'(x_q) + NB_W'(dx);
  assign ny = NB_W'(y_q) + NB_W'(dy);

  assign inb = !nx[NB_W-1] && !ny[NB_W-1]
            && (nx[COORD_W-1:0] < {1'b0, used_w})
            && (ny[COORD_W-1:0] < {1'b0, used_h});

  // in-grid coordinates always fit the index widths
  assign xe      = 16'(nx[COORD_W-1:0]);
  assign ye      = 16'(ny[COORD_W-1:0]);
  assign nb_addr = AW'(AW'(ye[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(xe[XW-1:0]);

  assign mem_we    = cmd_i.clr | (cmd_i.wr & inb);
  assign mem_re    = cmd_i.rd & inb;
  assign mem_wdata = !cmd_i.clr && (cmd_q == CMD_SET);
  assign mem_addr  = cmd_i.clr ? clr_cnt_q : nb_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= map_mem[mem_addr];
  end

  assign status_o.cmd      = cmd_q;
  assign status_o.diag     = diag_q;
  assign status_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

  assign free = s_inb_q & ~rdata_q;

  always_comb begin
    out_v_d = 1'b0;
    occ_d   = 1'b0;
    nv_d    = 1'b0;
    ox_d    = '0;
    oy_d    = '0;
    last_d  = 1'b1;
    if (cmd_i.ack) begin
      out_v_d = 1'b1;
    end else if (cmd_i.qresp) begin
      out_v_d = 1'b1;
      occ_d   = ~s_inb_q | rdata_q;
    end else if (cmd_i.eval && free && pend_v_q) begin
      // a newer neighbor exists, so the held one is not last
      out_v_d = 1'b1;
      nv_d    = 1'b1;
      ox_d    = pend_x_q;
      oy_d    = pend_y_q;
      last_d  = 1'b0;
    end else if (cmd_i.fin) begin
      out_v_d = 1'b1;
      if (pend_v_q) begin
        nv_d = 1'b1;
        ox_d = pend_x_q;
        oy_d = pend_y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= CFG_W'(256);
      grid_h_q  <= CFG_W'(256);
      clr_cnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_GRID_WIDTH) grid_w_q <= cfg_data_i;
        if (cfg_idx_i == REG_GRID_HEIGHT) grid_h_q <= cfg_data_i;
      end
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.ld || cmd_i.fin) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.eval && free) begin
        pend_v_q <= 1'b1;
      end
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      cmd_q  <= command_i;
      x_q    <= cell_x_i;
      y_q    <= cell_y_i;
      diag_q <= diagonal_i;
    end
    if (cmd_i.rd) begin
      s_inb_q <= inb;
      s_x_q   <= nx[COORD_W-1:0];
      s_y_q   <= ny[COORD_W-1:0];
    end
    if (cmd_i.eval && free) begin
      pend_x_q <= s_x_q;
      pend_y_q <= s_y_q;
    end
    if (out_v_d) begin
      occ_q  <= occ_d;
      nv_q   <= nv_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      last_q <= last_d;
    end
  end

  assign result_valid_o   = out_v_q;
  assign occupied_o       = occ_q;
  assign neighbor_valid_o = nv_q;
  assign neighbor_x_o     = ox_q;
  assign neighbor_y_o     = oy_q;
  assign last_o           = last_q;

  `GONX_ASSERT_NXT(a_ld_drops_pend, clk_i, rst_ni, cmd_i.ld, !pend_v_q,
                   "pending neighbor survived a new transaction")
  `GONX_ASSERT_NOW(a_mid_has_nb, clk_i, rst_ni, out_v_q && !last_q, nv_q,
                   "non-final result without a neighbor")
  `GONX_ASSERT_NXT(a_fin_emits_last, clk_i, rst_ni, cmd_i.fin, out_v_q && last_q,
                   "expand finished without a last result")

endmodule

@@ hdl/grid_occupancy_neighbor_expand_top.sv @@
// Channel    | Ports                                              | Handshake
// -----------+----------------------------------------------------+-------------------------
// command in | command_i cell_x_i cell_y_i diagonal_i             | start high, busy low
// result out | occupied_o neighbor_valid_o neighbor_x_o/_y_o last_o | result_valid_o, 1 cycle
// config     | cfg_idx_i cfg_data_i                               | cfg_we_i, any edge
//
// Expand visits four neighbors, or eight with diagonal_i. The map sits in a
// single-port memory, and expand walks one neighbor read per cycle through it.
// After reset a clearing pass writes every map cell to free, with busy high;
// config writes are taken meanwhile.
// Results are presented for exactly one cycle; there is no output stall.
module grid_occupancy_neighbor_expand_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [gonx_pkg::CMD_W-1:0]          command_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_x_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_y_i,
  input  logic                                diagonal_i,
  // result channel
  output logic                                result_valid_o,
  output logic                                occupied_o,
  output logic                                neighbor_valid_o,
  output logic signed [gonx_pkg::COORD_W-1:0] neighbor_x_o,
  output logic signed [gonx_pkg::COORD_W-1:0] neighbor_y_o,
  output logic                                last_o,
  // configuration: index 0 grid width, index 1 grid height
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [gonx_pkg::CFG_W-1:0]          cfg_data_i
);
  import gonx_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: clearing pass, dispatch per command, neighbor walk.
  gonx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Map memory, bounds check, address generation and result register.
  // Expand holds one found neighbor back so the final one can carry last.
  gonx_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .diagonal_i       (diagonal_i),
    .result_valid_o   (result_valid_o),
    .occupied_o       (occupied_o),
    .neighbor_valid_o (neighbor_valid_o),
    .neighbor_x_o     (neighbor_x_o),
    .neighbor_y_o     (neighbor_y_o),
    .last_o           (last_o)
  );

endmodule

@@ bench/grid_occupancy_checker.sv @@
`timescale 1ns / 1ps

module grid_occupancy_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [gonx_pkg::CMD_W-1:0]          command_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_x_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] cell_y_i,
  input  logic                                diagonal_i,
  input  logic                                result_valid_i,
  input  logic                                occupied_i,
  input  logic                                neighbor_valid_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] neighbor_x_i,
  input  logic signed [gonx_pkg::COORD_W-1:0] neighbor_y_i,
  input  logic                                last_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [gonx_pkg::CFG_W-1:0]          cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import gonx_pkg::*;

  localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic                      occupied;
    logic                      nb_valid;
    logic [COORD_W-1:0]        nb_x;
    logic [COORD_W-1:0]        nb_y;
    logic                      last;
  } grid_result_t;

  // N S E W, then NE SE NW SW
  int step_x [8] = '{0, 0, 1, -1, 1, 1, -1, -1};
  int step_y [8] = '{1, -1, 0, 0, 1, -1, 1, -1};

  grid_result_t       due_results [$];
  bit                 blocked_cells [MAP_CELLS];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  int                 mismatches = 0;
  int                 waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic bit in_grid(input int x, input int y);
    int uw;
    int uh;
    uw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    uh = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    return x >= 0 && y >= 0 && x < uw && y < uh;
  endfunction

  function automatic bit cell_blocked(input int x, input int y);
    if (!in_grid(x, y)) return 1'b1;
    return blocked_cells[y * MAX_WIDTH + x];
  endfunction

  // Push the results one accepted command produces.
  task automatic predict_command(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                 input logic diag);
    grid_result_t r;
    grid_result_t held;
    bit           have_held;
    int           nx;
    int           ny;
    r = '0;
    r.last = 1'b1;
    have_held = 1'b0;
    case (cmd)
      CMD_SET, CMD_CLEAR: begin
        if (in_grid(x, y)) blocked_cells[y * MAX_WIDTH + x] = (cmd == CMD_SET);
        due_results.push_back(r);
      end
      CMD_QUERY: begin
        r.occupied = cell_blocked(x, y);
        due_results.push_back(r);
      end
      CMD_EXPAND: begin
        for (int d = 0; d < (diag ? 8 : 4); d++) begin
          nx = x + step_x[d];
          ny = y + step_y[d];
          if (!cell_blocked(nx, ny)) begin
            if (have_held) due_results.push_back(held);
            held          = '0;
            held.nb_valid = 1'b1;
            held.nb_x     = COORD_W'(nx);
            held.nb_y     = COORD_W'(ny);
            have_held     = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          due_results.push_back(held);
        end else begin
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t wanted;
    if (!rst_ni) begin
      due_results.delete();
      for (int i = 0; i < MAP_CELLS; i++) blocked_cells[i] = 1'b0;
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      waiting    = 0;
    end else begin
      // Retire the result first: it belongs to an earlier transaction.
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual occ=%b nv=%b x=%h y=%h last=%b",
                   $time, occupied_i, neighbor_valid_i, neighbor_x_i, neighbor_y_i, last_i);
          mismatches++;
        end else begin
          wanted = due_results.pop_front();
          check_field("occupied", COORD_W'(wanted.occupied), COORD_W'(occupied_i));
          check_field("neighbor_valid", COORD_W'(wanted.nb_valid), COORD_W'(neighbor_valid_i));
          check_field("neighbor_x", wanted.nb_x, neighbor_x_i);
          check_field("neighbor_y", wanted.nb_y, neighbor_y_i);
          check_field("last", COORD_W'(wanted.last), COORD_W'(last_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_GRID_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (start_i && !busy_i)
        predict_command(command_i, int'(cell_x_i), int'(cell_y_i), diagonal_i);
      waiting = due_results.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the occupancy grid. The checker beside the DUT
// tracks the map and the size registers and compares every result.
module testbench;
  import gonx_pkg::*;

  localparam int MAX_DIM         = 256;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 31;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [CMD_W-1:0]          command = CMD_SET;
  logic signed [COORD_W-1:0] cell_x = '0;
  logic signed [COORD_W-1:0] cell_y = '0;
  logic                      diagonal = 1'b0;
  logic                      result_valid;
  logic                      occupied;
  logic                      neighbor_valid;
  logic signed [COORD_W-1:0] neighbor_x;
  logic signed [COORD_W-1:0] neighbor_y;
  logic                      last;
  logic                      cfg_we = 1'b0;
  logic                      cfg_idx = REG_GRID_WIDTH;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        fail_count;
  int                        pending;

  // Size settings per phase: extremes (0, 1, 256, saturating 511) and a few
  // small grids where the map fills up and edges come into play.
  int phase_w [NUM_PHASES] = '{1, 8, 0, 511, 12, 300, 16, 2, 256, 256};
  int phase_h [NUM_PHASES] = '{1, 6, 5, 3, 0, 511, 16, 256, 1, 256};

  grid_occupancy_neighbor_expand_top #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .command_i       (command),
    .cell_x_i        (cell_x),
    .cell_y_i        (cell_y),
    .diagonal_i      (diagonal),
    .result_valid_o  (result_valid),
    .occupied_o      (occupied),
    .neighbor_valid_o(neighbor_valid),
    .neighbor_x_o    (neighbor_x),
    .neighbor_y_o    (neighbor_y),
    .last_o          (last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  grid_occupancy_checker #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command),
    .cell_x_i      (cell_x),
    .cell_y_i      (cell_y),
    .diagonal_i    (diagonal),
    .result_valid_i(result_valid),
    .occupied_i    (occupied),
    .neighbor_valid_i(neighbor_valid),
    .neighbor_x_i  (neighbor_x),
    .neighbor_y_i  (neighbor_y),
    .last_i        (last),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Called at a falling edge. Leaves start high so a following transaction
  // can go back to back; the caller drops it when idling.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic diag);
    start    <= 1'b1;
    command  <= cmd;
    cell_x   <= x;
    cell_y   <= y;
    diagonal <= diag;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Wait until every result has come back and the block is idle.
  task automatic settle();
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_grid(input int w, input int h);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_GRID_WIDTH;
    cfg_data <= CFG_W'(w);
    @(negedge clk);
    cfg_idx  <= REG_GRID_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly a small window around a hot spot so that sets, clears and
  // expands collide; some grid edges and some fully random 10-bit values.
  function automatic logic [COORD_W-1:0] pick_coord(input int extent, input int anchor);
    int v;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 1023));
      1: v = $urandom_range(0, 1) ? extent - int'($urandom_range(0, 1))
                                  : -int'($urandom_range(0, 1));
      default: v = anchor + int'($urandom_range(0, 9)) - 1;
    endcase
    return COORD_W'(v);
  endfunction

  task automatic run_random(input int w_reg, input int h_reg, input int n_items);
    int               ext_x;
    int               ext_y;
    int               anc_x;
    int               anc_y;
    int               sent;
    int               burst;
    int               gap;
    int               pick;
    logic [CMD_W-1:0] cmd;
    ext_x = (w_reg > MAX_DIM) ? MAX_DIM : w_reg;
    ext_y = (h_reg > MAX_DIM) ? MAX_DIM : h_reg;
    anc_x = (ext_x <= 8) ? 0 : int'($urandom_range(0, ext_x - 8));
    anc_y = (ext_y <= 8) ? 0 : int'($urandom_range(0, ext_y - 8));
    sent  = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_SET;
        else if (pick < 45) cmd = CMD_CLEAR;
        else if (pick < 65) cmd = CMD_QUERY;
        else                cmd = CMD_EXPAND;
        send_item(cmd, pick_coord(ext_x, anc_x), pick_coord(ext_y, anc_y),
                  1'($urandom_range(0, 1)));
        burst--;
        sent++;
      end
      // A quarter of the bursts run straight into the next one.
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    // The clearing sweep after reset holds busy high.
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // Directed part on the full 256 x 256 grid.
    send_item(CMD_SET, 0, 0, 1'b0);
    send_item(CMD_SET, 255, 255, 1'b0);
    send_item(CMD_SET, -1, 3, 1'b0);          // left of the grid, ignored
    send_item(CMD_SET, 256, 0, 1'b0);         // right of the grid, ignored
    send_item(CMD_SET, -512, 511, 1'b1);      // field extremes, ignored
    send_item(CMD_QUERY, 0, 0, 1'b0);
    send_item(CMD_QUERY, 255, 255, 1'b0);
    send_item(CMD_QUERY, -1, 0, 1'b0);        // outside counts as occupied
    send_item(CMD_QUERY, 511, -512, 1'b1);
    send_item(CMD_QUERY, 5, 5, 1'b0);
    send_item(CMD_CLEAR, 255, 255, 1'b0);
    send_item(CMD_QUERY, 255, 255, 1'b0);
    send_item(CMD_SET, 1, 1, 1'b0);
    send_item(CMD_SET, 0, 1, 1'b0);
    send_item(CMD_EXPAND, 0, 0, 1'b0);        // corner, one blocked neighbor
    send_item(CMD_EXPAND, 0, 0, 1'b1);
    send_item(CMD_EXPAND, 255, 255, 1'b1);    // far corner
    send_item(CMD_EXPAND, -5, -5, 1'b1);      // no neighbor in the grid
    send_item(CMD_EXPAND, -1, -1, 1'b1);      // only neighbor is blocked
    send_item(CMD_EXPAND, 256, 100, 1'b0);    // reaches in from outside
    send_item(CMD_EXPAND, 100, 100, 1'b1);    // all eight free
    send_item(CMD_CLEAR, 0, 0, 1'b1);
    send_item(CMD_EXPAND, -1, -1, 1'b1);
    send_item(CMD_EXPAND, 511, 511, 1'b1);
    send_item(CMD_EXPAND, -512, -512, 1'b0);
    start <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_grid(phase_w[p], phase_h[p]);
      run_random(phase_w[p], phase_h[p], ITEMS_PER_PHASE);
    end

    // Drain, then leave room for any stray result.
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS grid_occupancy_neighbor_expand_top");
    end else begin
      $display("FAIL grid_occupancy_neighbor_expand_top");
    end
    $finish;
  end

  // Watchdog: covers the clearing sweep plus every transaction at its slowest.
  initial begin
    #10_000_000;
    $display("FAIL grid_occupancy_neighbor_expand_top");
    $finish;
  end

endmodule
